@@ hw/rtl/fprl_pkg.sv @@
package fprl_pkg;

    localparam int unsigned REQ_W   = 2;
    localparam int unsigned FRAME_W = 32;
    localparam int unsigned FLAG_W  = 8;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned SIZE_W  = 33;
    localparam int unsigned HSLOT_W = 4;
    localparam int unsigned HGEN_W  = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_CLEAN  = 2'd1,
        REQ_LOCK   = 2'd2,
        REQ_WAIT   = 2'd3
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES      = 1'b1;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FRAME_W-1:0] frame_number;
        logic [FLAG_W-1:0]  sync_flag;
        logic [ADDR_W-1:0]  range_begin;
        logic [ADDR_W-1:0]  range_length;
        logic [HSLOT_W-1:0] lock_slot;
        logic [HGEN_W-1:0]  lock_gen;
    } t_in_word;

    typedef struct packed {
        logic [HSLOT_W-1:0] handle_slot;
        logic [HGEN_W-1:0]  handle_gen;
        logic               ok;
        logic               table_full;
    } t_out_word;

    // half-open overlap in 34-bit arithmetic
    function automatic logic spans_overlap(
        input logic [ADDR_W-1:0] a0, input logic [ADDR_W-1:0] alen,
        input logic [ADDR_W-1:0] b0, input logic [SIZE_W-1:0] blen);
        logic [SIZE_W:0] ae;
        logic [SIZE_W:0] be;
        ae = {2'b00, a0} + {2'b00, alen};
        be = {2'b00, b0} + {1'b0, blen};
        return ({2'b00, a0} < be) && ({2'b00, b0} < ae);
    endfunction

endpackage

@@ hw/rtl/fprl_ram.sv @@
module fprl_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ hw/rtl/fence_pool_and_range_lock_table_top.sv @@
// Sync-slot pool with a table of locked byte ranges.
// Input channel: i_in_valid / o_in_stall carry one request word (t_in_word).
// Output channel: o_out_valid / i_out_stall carry one result word per request.
// Config channel: i_cfg_valid / o_cfg_ready, index 0 expiry mode, 1 frames in
// flight; written only while the block is idle.
// A request is taken only while no other is at work. Create and clean walk
// the pool one slot a cycle (clean reads the slot frame memory), lock walks
// the lock table one entry a cycle and stops at the first overlapping entry,
// and wait reads, fetches and evaluates each used lock entry in turn. Both
// memories have a registered read. Once the result is loaded the block
// returns to idle, where the next request is taken.
// The result sits in an output register; while i_out_stall is high the word
// holds and the next request may be accepted and worked on, but its result
// waits until the register frees.
// Reset (synchronous, active low) clears the exists, busy and generation bits
// of the pool and the lock count, and sets expiry mode 0 and three frames in
// flight; memory contents are not cleared, no clearing pass is needed.
module fence_pool_and_range_lock_table_top
    import fprl_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = 16,
    parameter int unsigned LOCK_DEPTH = 16,
    parameter int unsigned GEN_WIDTH  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned PW = $clog2(POOL_DEPTH);
    localparam int unsigned LW = $clog2(LOCK_DEPTH);
    localparam int unsigned PC = PW + 1;
    localparam int unsigned LC = LW + 1;
    localparam int unsigned LMW = ADDR_W + SIZE_W + HSLOT_W + GEN_WIDTH;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_PSCAN = 10'b0000000010,
        ST_PWR   = 10'b0000000100,
        ST_LSCAN = 10'b0000001000,
        ST_LWR   = 10'b0000010000,
        ST_WRD   = 10'b0000100000,
        ST_WGEN  = 10'b0001000000,
        ST_WEVAL = 10'b0010000000,
        ST_DONE  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    t_in_word r_req;
    logic r_mode;
    logic [CFG_DATA_W-1:0] r_fif;

    logic [POOL_DEPTH-1:0] r_exists, r_busy;
    logic [GEN_WIDTH-1:0] r_gen [POOL_DEPTH];
    logic [LC-1:0] r_used;

    logic [PC-1:0] r_pi;
    logic [LC-1:0] r_li, r_wi;
    logic r_found;
    logic [PW-1:0] r_fslot;
    logic r_err;
    t_out_word r_res;
    t_out_word r_out_word;
    logic r_out_valid;

    // slot frame memory
    logic             sf_we;
    logic [PW-1:0]    sf_waddr, sf_raddr;
    logic [FRAME_W-1:0] sf_wdata, sf_rdata;

    // lock memory
    logic             lm_we;
    logic [LW-1:0]    lm_waddr, lm_raddr;
    logic [LMW-1:0]   lm_wdata, lm_rdata;
    logic [LMW-1:0]   r_ent;

    fprl_ram #(.WIDTH(FRAME_W), .DEPTH(POOL_DEPTH)) u_frame (
        .i_clk(i_clk), .i_we(sf_we), .i_waddr(sf_waddr), .i_wdata(sf_wdata),
        .i_raddr(sf_raddr), .o_rdata(sf_rdata));
    fprl_ram #(.WIDTH(LMW), .DEPTH(LOCK_DEPTH)) u_lock (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_rdata));

    logic [ADDR_W-1:0]    e_start;
    logic [SIZE_W-1:0]    e_size;
    logic [HSLOT_W-1:0]   e_oslot;
    logic [GEN_WIDTH-1:0] e_ogen;
    assign {e_start, e_size, e_oslot, e_ogen} = r_ent;

    logic [ADDR_W-1:0]    l_start;
    logic [SIZE_W-1:0]    l_size;
    logic [HSLOT_W-1:0]   l_oslot;
    logic [GEN_WIDTH-1:0] l_ogen;
    assign {l_start, l_size, l_oslot, l_ogen} = lm_rdata;

    logic [GEN_WIDTH-1:0] req_gen;
    assign req_gen = GEN_WIDTH'(r_req.lock_gen);

    logic [PW-1:0] pi_idx;
    assign pi_idx = r_pi[PW-1:0];

    logic expire;
    logic [FRAME_W-1:0] fdiff;
    always_comb begin
        fdiff = r_req.frame_number - sf_rdata;
        if (!r_mode) begin
            expire = fdiff >= FRAME_W'(r_fif);
        end else begin
            expire = sf_rdata < r_req.frame_number;
        end
    end

    // first slot that does not exist yet
    logic fa_found;
    logic [PW-1:0] fa_idx;
    always_comb begin
        fa_found = 1'b0;
        fa_idx   = '0;
        for (int k = 0; k < POOL_DEPTH; k++) begin
            if (!fa_found && !r_exists[k]) begin
                fa_found = 1'b1;
                fa_idx   = PW'(k);
            end
        end
    end

    // merged span
    logic [SIZE_W:0] m_e0, m_e1, m_ne;
    logic [ADDR_W-1:0] m_ns;
    logic [SIZE_W:0] m_sz;
    always_comb begin
        m_e0 = {2'b00, l_start} + {1'b0, l_size};
        m_e1 = {2'b00, r_req.range_begin} + {2'b00, r_req.range_length};
        m_ns = (r_req.range_begin < l_start) ? r_req.range_begin : l_start;
        m_ne = (m_e1 > m_e0) ? m_e1 : m_e0;
        m_sz = m_ne - {2'b00, m_ns};
    end

    logic l_ov;
    assign l_ov = spans_overlap(r_req.range_begin, r_req.range_length, l_start, l_size);
    logic e_ov;
    assign e_ov = spans_overlap(r_req.range_begin, r_req.range_length, e_start, e_size);

    // owner generation, out-of-pool reads zero
    logic [GEN_WIDTH-1:0] own_gen;
    logic own_in;
    logic [PW-1:0] own_idx;
    always_comb begin
        own_in  = 32'(e_oslot) < POOL_DEPTH;
        own_idx = PW'(e_oslot);
        own_gen = own_in ? r_gen[own_idx] : '0;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state  = r_state;
        sf_we    = 1'b0;
        sf_waddr = r_fslot;
        sf_wdata = r_req.frame_number;
        sf_raddr = pi_idx;
        lm_we    = 1'b0;
        lm_waddr = r_wi[LW-1:0];
        lm_wdata = r_ent;
        lm_raddr = r_li[LW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                sf_raddr = '0;
                lm_raddr = '0;
                if (i_in_valid) begin
                    unique case (i_in_word.req_type) inside
                        REQ_CREATE, REQ_CLEAN: n_state = ST_PSCAN;
                        REQ_LOCK: n_state = ST_LSCAN;
                        default: n_state = ST_WRD;
                    endcase
                end
            end
            ST_PSCAN: begin
                sf_raddr = PW'(r_pi + 1'b1);
                if (r_req.req_type == REQ_CREATE) begin
                    if (r_pi == PC'(POOL_DEPTH)) n_state = ST_PWR;
                end else if (r_pi == PC'(POOL_DEPTH)) begin
                    n_state = ST_DONE;
                end
            end
            ST_PWR: begin
                sf_we = r_found;
                n_state = ST_DONE;
            end
            ST_LSCAN: begin
                if (l_ov && r_li < r_used) lm_raddr = LW'(r_li);
                else lm_raddr = LW'(r_li + 1'b1);
                if (r_li >= r_used || r_li == LC'(LOCK_DEPTH) ||
                    (l_ov && r_li < r_used)) begin
                    n_state = ST_LWR;
                end
            end
            ST_LWR: begin
                n_state = ST_DONE;
                if (r_found) begin
                    lm_we = 1'b1;
                    lm_waddr = r_wi[LW-1:0];
                    lm_wdata = {m_ns, m_sz[SIZE_W-1:0], r_req.lock_slot, req_gen};
                end else if (r_used < LC'(LOCK_DEPTH)) begin
                    lm_we = 1'b1;
                    lm_waddr = r_used[LW-1:0];
                    lm_wdata = {r_req.range_begin, 1'b0, r_req.range_length,
                                r_req.lock_slot, req_gen};
                end
            end
            ST_WRD: begin
                if (r_li >= r_used || r_li == LC'(LOCK_DEPTH)) n_state = ST_DONE;
                else n_state = ST_WGEN;
            end
            ST_WGEN: n_state = ST_WEVAL;
            ST_WEVAL: begin
                lm_raddr = LW'(r_li);
                if (own_gen == e_ogen && !e_ov) begin
                    lm_we = 1'b1;
                    lm_waddr = r_wi[LW-1:0];
                    lm_wdata = r_ent;
                end
                n_state = ST_WRD;
            end
            ST_DONE: n_state = ST_OUT;
            ST_OUT: if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= 1'b0;
            r_fif <= CFG_DATA_W'(3);
            r_exists <= '0;
            r_busy <= '0;
            r_used <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < POOL_DEPTH; k++) r_gen[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_out_word <= r_res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_EXPIRY_MODE) r_mode <= i_cfg_data[0];
                else r_fif <= i_cfg_data;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_req <= i_in_word;
                    r_pi <= '0;
                    r_li <= '0;
                    r_wi <= '0;
                    r_found <= 1'b0;
                    r_err <= 1'b0;
                    r_res <= '{handle_slot: '0, handle_gen: '0, ok: 1'b1,
                               table_full: 1'b0};
                end
                ST_PSCAN: begin
                    r_pi <= r_pi + 1'b1;
                    if (r_req.req_type == REQ_CREATE) begin
                        // first free existing slot, else first absent slot
                        if (r_pi == PC'(POOL_DEPTH)) begin
                            if (!r_found && fa_found) begin
                                r_found <= 1'b1;
                                r_fslot <= fa_idx;
                            end
                        end else if (!r_found && r_exists[pi_idx] && !r_busy[pi_idx]) begin
                            r_found <= 1'b1;
                            r_fslot <= pi_idx;
                        end
                    end else if (r_pi < PC'(POOL_DEPTH)) begin
                        if (r_exists[pi_idx] && r_busy[pi_idx] && expire)
                            r_busy[pi_idx] <= 1'b0;
                    end
                end
                ST_PWR: begin
                    if (r_found) begin
                        r_busy[r_fslot] <= 1'b1;
                        r_res.handle_slot <= HSLOT_W'(r_fslot);
                        if (r_exists[r_fslot]) begin
                            r_gen[r_fslot] <= r_gen[r_fslot] + 1'b1;
                            r_res.handle_gen <= HGEN_W'(r_gen[r_fslot] + 1'b1);
                        end else begin
                            r_exists[r_fslot] <= 1'b1;
                            r_gen[r_fslot] <= '0;
                        end
                    end else begin
                        r_res.ok <= 1'b0;
                        r_res.table_full <= 1'b1;
                    end
                end
                ST_LSCAN: begin
                    r_li <= r_li + 1'b1;
                    if (l_ov && r_li < r_used && r_li != LC'(LOCK_DEPTH)) begin
                        r_found <= 1'b1;
                        r_wi <= r_li;
                    end
                end
                ST_LWR: begin
                    if (!r_found) begin
                        if (r_used < LC'(LOCK_DEPTH)) begin
                            r_used <= r_used + 1'b1;
                        end else begin
                            r_res.ok <= 1'b0;
                            r_res.table_full <= 1'b1;
                        end
                    end
                end
                ST_WRD: begin
                    if (r_li >= r_used || r_li == LC'(LOCK_DEPTH)) begin
                        r_used <= r_wi;
                        r_res.ok <= !r_err;
                    end
                end
                ST_WGEN: r_ent <= lm_rdata;
                ST_WEVAL: begin
                    r_li <= r_li + 1'b1;
                    if (own_gen != e_ogen) begin
                        r_err <= !(own_gen > e_ogen);
                    end else if (e_ov) begin
                        if (own_in) r_busy[own_idx] <= 1'b0;
                    end else begin
                        r_wi <= r_wi + 1'b1;
                    end
                end
                ST_DONE: ;
                ST_OUT: ;
                default: ;
            endcase
        end
    end

endmodule

@@ hw/rtl/fprl_checker.sv @@
module fprl_checker
    import fprl_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word,
    input logic      o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result changed");

    a_busy_no_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !o_cfg_ready)
        else $error("config ready while busy");

    a_take_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken at once");

    a_full_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.table_full |-> !o_out_word.ok)
        else $error("full with ok");

endmodule

bind fence_pool_and_range_lock_table_top fprl_checker u_fprl_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_word(o_out_word),
    .o_cfg_ready(o_cfg_ready));

@@ tb/tb_fence_pool_and_range_lock_table_top.sv @@
`timescale 1ns / 100ps

module tb_fence_pool_and_range_lock_table_top;
    import fprl_pkg::*;

    localparam int unsigned SLOTS      = 16;
    localparam int unsigned LOCKS      = 16;
    localparam int unsigned DRAIN_WAIT = 2 * LOCKS + 40;
    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned RAND_ITEMS = 2000;
    localparam int unsigned IN_W       = $bits(t_in_word);

    class lock_table_scoreboard;
        bit          expiry_mode;
        bit [3:0]    frames_in_flight;
        bit          slot_live [SLOTS];
        bit          slot_taken [SLOTS];
        bit [31:0]   slot_stamp [SLOTS];
        bit [15:0]   slot_gen [SLOTS];
        bit [31:0]   lk_start [LOCKS];
        bit [32:0]   lk_size [LOCKS];
        bit [3:0]    lk_slot [LOCKS];
        bit [15:0]   lk_gen [LOCKS];
        int          lk_count;
        t_out_word   pending_q [$];
        int          errors;

        function new();
            expiry_mode = 1'b0;
            frames_in_flight = 4'd3;
            foreach (slot_live[i]) begin
                slot_live[i] = 0;
                slot_taken[i] = 0;
                slot_gen[i] = '0;
            end
            lk_count = 0;
            errors = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            if (idx == CFG_EXPIRY_MODE) expiry_mode = data[0];
            else frames_in_flight = data;
        endfunction

        function bit overlaps(bit [31:0] a0, bit [31:0] alen, bit [31:0] b0, bit [32:0] blen);
            bit [33:0] a_end;
            bit [33:0] b_end;
            a_end = {2'b00, a0} + {2'b00, alen};
            b_end = {2'b00, b0} + {1'b0, blen};
            return ({2'b00, a0} < b_end) && ({2'b00, b0} < a_end);
        endfunction

        function t_out_word note_request(t_in_word w);
            t_out_word r;
            bit        done;
            bit        err;
            int        keep;
            bit [33:0] s0, e0, e1, ns, ne;
            bit [15:0] g;
            r = '0;
            r.ok = 1'b1;
            done = 0;
            case (t_req'(w.req_type))
                REQ_CREATE: begin
                    for (int i = 0; i < SLOTS && !done; i++)
                        if (slot_live[i] && !slot_taken[i]) begin
                            slot_taken[i] = 1;
                            slot_stamp[i] = w.frame_number;
                            slot_gen[i] = slot_gen[i] + 16'd1;
                            r.handle_slot = 4'(i);
                            r.handle_gen = slot_gen[i];
                            done = 1;
                        end
                    for (int i = 0; i < SLOTS && !done; i++)
                        if (!slot_live[i]) begin
                            slot_live[i] = 1;
                            slot_taken[i] = 1;
                            slot_stamp[i] = w.frame_number;
                            slot_gen[i] = '0;
                            r.handle_slot = 4'(i);
                            done = 1;
                        end
                    if (!done) begin
                        r.ok = 1'b0;
                        r.table_full = 1'b1;
                    end
                end
                REQ_CLEAN: begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_live[i] && slot_taken[i]) begin
                            if (expiry_mode == 1'b0) begin
                                if (32'(w.frame_number - slot_stamp[i]) >= 32'(frames_in_flight))
                                    slot_taken[i] = 0;
                            end else if (slot_stamp[i] < w.frame_number) begin
                                slot_taken[i] = 0;
                            end
                        end
                end
                REQ_LOCK: begin
                    for (int i = 0; i < lk_count && !done; i++)
                        if (overlaps(w.range_begin, w.range_length, lk_start[i], lk_size[i])) begin
                            s0 = {2'b00, lk_start[i]};
                            e0 = s0 + {1'b0, lk_size[i]};
                            e1 = {2'b00, w.range_begin} + {2'b00, w.range_length};
                            ns = (w.range_begin < lk_start[i]) ? {2'b00, w.range_begin} : s0;
                            ne = (e1 > e0) ? e1 : e0;
                            lk_start[i] = ns[31:0];
                            lk_size[i] = 33'(ne - ns);
                            lk_slot[i] = w.lock_slot;
                            lk_gen[i] = w.lock_gen;
                            done = 1;
                        end
                    if (!done) begin
                        if (lk_count < LOCKS) begin
                            lk_start[lk_count] = w.range_begin;
                            lk_size[lk_count] = {1'b0, w.range_length};
                            lk_slot[lk_count] = w.lock_slot;
                            lk_gen[lk_count] = w.lock_gen;
                            lk_count++;
                        end else begin
                            r.ok = 1'b0;
                            r.table_full = 1'b1;
                        end
                    end
                end
                default: begin
                    err = 0;
                    keep = 0;
                    for (int i = 0; i < lk_count; i++) begin
                        g = slot_gen[lk_slot[i]];
                        if (g != lk_gen[i]) begin
                            err = !(g > lk_gen[i]);
                        end else if (overlaps(w.range_begin, w.range_length,
                                              lk_start[i], lk_size[i])) begin
                            slot_taken[lk_slot[i]] = 0;
                        end else begin
                            lk_start[keep] = lk_start[i];
                            lk_size[keep] = lk_size[i];
                            lk_slot[keep] = lk_slot[i];
                            lk_gen[keep] = lk_gen[i];
                            keep++;
                        end
                    end
                    lk_count = keep;
                    r.ok = !err;
                end
            endcase
            pending_q = {pending_q, r};
            return r;
        endfunction

        function void check_result(t_out_word got);
            t_out_word exp_w;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending_q.pop_front();
            if (got.handle_slot !== exp_w.handle_slot) begin
                $display("%0t: handle_slot expected %0d actual %0d", $time,
                         exp_w.handle_slot, got.handle_slot);
                errors++;
            end
            if (got.handle_gen !== exp_w.handle_gen) begin
                $display("%0t: handle_gen expected %0d actual %0d", $time,
                         exp_w.handle_gen, got.handle_gen);
                errors++;
            end
            if (got.ok !== exp_w.ok) begin
                $display("%0t: ok expected %0d actual %0d", $time, exp_w.ok, got.ok);
                errors++;
            end
            if (got.table_full !== exp_w.table_full) begin
                $display("%0t: table_full expected %0d actual %0d", $time,
                         exp_w.table_full, got.table_full);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lock_table_scoreboard sb;
    bit [3:0]  handle_slots [$];
    bit [15:0] handle_gens [$];
    bit [31:0] frame_now;
    bit        hold_req;
    int        idle_cycles;

    fence_pool_and_range_lock_table_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic send_word(t_in_word w);
        t_out_word r;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        r = sb.note_request(w);
        if (t_req'(w.req_type) == REQ_CREATE && r.ok) begin
            handle_slots = {handle_slots, r.handle_slot};
            handle_gens = {handle_gens, r.handle_gen};
            if (handle_slots.size() > 24) begin
                void'(handle_slots.pop_front());
                void'(handle_gens.pop_front());
            end
        end
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_word make_word(t_req kind, bit [31:0] rb, bit [31:0] rl,
                                           bit [3:0] ls, bit [15:0] lg);
        t_in_word w;
        w = '0;
        w.req_type = kind;
        w.frame_number = frame_now;
        w.sync_flag = 8'($urandom);
        w.range_begin = rb;
        w.range_length = rl;
        w.lock_slot = ls;
        w.lock_gen = lg;
        return w;
    endfunction

    function automatic t_in_word random_word();
        t_in_word w;
        int pick;
        int k;
        bit [3:0]  ls;
        bit [15:0] lg;
        pick = $urandom_range(0, 99);
        frame_now = frame_now + $urandom_range(0, 2);
        ls = 4'($urandom);
        lg = 16'($urandom_range(0, 3));
        if (handle_slots.size() != 0 && $urandom_range(0, 9) < 8) begin
            k = $urandom_range(0, handle_slots.size() - 1);
            ls = handle_slots[k];
            lg = handle_gens[k];
            case ($urandom_range(0, 9))
                0: lg = lg + 16'd1;
                1: lg = lg - 16'd1;
                default: ;
            endcase
        end
        if (pick < 28) begin
            w = make_word(REQ_CREATE, $urandom, $urandom, 4'($urandom), 16'($urandom));
        end else if (pick < 43) begin
            w = make_word(REQ_CLEAN, $urandom, $urandom, 4'($urandom), 16'($urandom));
        end else if (pick < 73) begin
            w = make_word(REQ_LOCK, $urandom_range(0, 255), $urandom_range(1, 64), ls, lg);
        end else if (pick < 93) begin
            w = make_word(REQ_WAIT, $urandom_range(0, 255), $urandom_range(1, 96),
                          4'($urandom), 16'($urandom));
        end else begin
            w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
            if (t_req'(w.req_type) == REQ_CREATE || t_req'(w.req_type) == REQ_CLEAN)
                frame_now = w.frame_number;
        end
        return w;
    endfunction

    task automatic run_random(int count);
        int left;
        left = count;
        while (left > 0) begin
            for (int b = $urandom_range(1, 20); b > 0 && left > 0; b--) begin
                send_word(random_word());
                left--;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
        end
    endtask

    task automatic run_directed();
        frame_now = 32'd0;
        for (int i = 0; i < SLOTS + 1; i++) begin
            send_word(make_word(REQ_CREATE, '0, 32'd1, '0, '0));
            frame_now = (i == 0) ? 32'hFFFF_FFFF : 32'd0;
        end
        send_word(make_word(REQ_LOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15, 16'hFFFF));
        send_word(make_word(REQ_LOCK, 32'h0, 32'hFFFF_FFFF, 4'd0, 16'd0));
        send_word(make_word(REQ_LOCK, 32'd10, 32'd0, 4'd1, 16'd0));
        send_word(make_word(REQ_WAIT, 32'd5, 32'd0, '0, '0));
        frame_now = 32'd40;
        send_word(make_word(REQ_CLEAN, '0, 32'd1, '0, '0));
        send_word(make_word(REQ_CREATE, '0, 32'd1, '0, '0));
        send_word(make_word(REQ_WAIT, 32'd0, 32'hFFFF_FFFF, '0, '0));
        for (int i = 0; i < LOCKS + 1; i++)
            send_word(make_word(REQ_LOCK, 32'(i * 8), 32'd4, 4'(i), 16'(i & 1)));
        send_word(make_word(REQ_WAIT, 32'd16, 32'd8, '0, '0));
        send_word(make_word(REQ_WAIT, 32'd0, 32'hFFFF_FFFF, '0, '0));
    endtask

    always @(posedge i_clk) begin
        int phase_cnt;
        int pattern;
        int hold_cnt;
        bit hold_seen;
        bit next_stall;
        if (o_out_valid && !i_out_stall) sb.check_result(o_out_word);
        // one long hold per request of the sender
        if (hold_req && !hold_seen) begin
            hold_cnt = HOLD_LEN;
            hold_seen = 1'b1;
        end
        if (!hold_req) hold_seen = 1'b0;
        phase_cnt++;
        if (phase_cnt % 64 == 0) pattern = $urandom_range(0, 2);
        case (pattern)
            0: next_stall = 1'b0;
            1: next_stall = 1'($urandom_range(0, 1));
            default: next_stall = (phase_cnt % 4 == 0);
        endcase
        if (hold_cnt > 0) begin
            hold_cnt--;
            next_stall = 1'b1;
        end
        i_out_stall <= i_rst_n ? next_stall : 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        sb = new();
        hold_req = 1'b0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_EXPIRY_MODE;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain();

        write_reg(CFG_FRAMES, 4'd1);
        run_random(RAND_ITEMS / 4);
        hold_req = 1'b1;
        run_random(60);
        hold_req = 1'b0;
        drain();

        write_reg(CFG_FRAMES, 4'd15);
        frame_now = 32'hFFFF_FF00;
        run_random(RAND_ITEMS / 4);
        drain();

        write_reg(CFG_EXPIRY_MODE, 4'd1);
        run_random(RAND_ITEMS / 4);
        drain();

        write_reg(CFG_EXPIRY_MODE, 4'd0);
        write_reg(CFG_FRAMES, 4'd3);
        run_random(RAND_ITEMS / 4);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/fprl_pkg.sv
hw/rtl/fprl_ram.sv
hw/rtl/fence_pool_and_range_lock_table_top.sv
hw/rtl/fprl_checker.sv
tb/tb_fence_pool_and_range_lock_table_top.sv
